@@ rtl/keyword_substitution_cipher_top_macros.svh @@
// ----------------------------------------------------------------------------
// Keyword substitution cipher assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// same-cycle implication
`define KSC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define KSC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/ksc_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Item types, command codes, letter constants and letter classification.
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = $clog2(ALPHABET_SIZE);
    localparam int FILL_W        = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        FUNC_KEY   = 2'd0,
        FUNC_SEAL  = 2'd1,
        FUNC_TEXT  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       key_not_ready;
    } out_item_t;

    typedef struct packed {
        logic                is_letter;
        logic                is_lower;
        logic [LETTER_W-1:0] idx;
    } letter_t;

    function automatic letter_t classify(input logic [7:0] ch);
        letter_t    res;
        logic [7:0] diff;
        res  = '0;
        diff = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            diff          = ch - CHAR_UPPER_A;
            res.is_letter = 1'b1;
            res.idx       = diff[LETTER_W-1:0];
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            diff          = ch - CHAR_LOWER_A;
            res.is_letter = 1'b1;
            res.is_lower  = 1'b1;
            res.idx       = diff[LETTER_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/ksc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/keyword_substitution_cipher_top.sv @@
// ----------------------------------------------------------------------------
// Keyword substitution cipher
// Builds a keyword substitution alphabet and enciphers or deciphers text.
// ----------------------------------------------------------------------------
// Keyword, clear and text items are taken one per cycle while no seal walk runs
// and the output is not stalled; a text item's result passes through the table
// read, then the output register. A seal item walks the 26 letters from Z down
// to A, one letter a cycle, and the input stalls while it walks. Forward and
// inverse tables sit in two 26x5 RAMs that are written together each time a
// letter is placed, so no separate inverse pass and no clearing pass are needed.
// Write decrypt_mode only while no item is in flight.
module keyword_substitution_cipher_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ksc_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output ksc_pkg::out_item_t out_item
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEAL = 2'b10
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_letter;
        logic       is_lower;
        logic       sealed;
    } s1_t;

    state_t                           state_reg, state_next;
    logic [ksc_pkg::LETTER_W-1:0]     walk_reg, walk_next;
    logic [ksc_pkg::ALPHABET_SIZE-1:0] used_reg, used_next;
    logic [ksc_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic                             sealed_reg, sealed_next;
    logic                             decrypt_mode_reg, decrypt_mode_next;
    logic                             s1_valid_reg, s1_valid_next;
    s1_t                              s1_reg, s1_next;
    logic                             out_valid_reg, out_valid_next;
    ksc_pkg::out_item_t               out_item_reg, out_item_next;

    ksc_pkg::letter_t                 letter;
    logic                             accept;
    logic                             is_text;
    logic                             key_we;
    logic                             seal_we;
    logic                             ram_we;
    logic [ksc_pkg::LETTER_W-1:0]     wr_letter;
    logic [ksc_pkg::LETTER_W-1:0]     fill_addr;
    logic [ksc_pkg::LETTER_W-1:0]     fwd_rdata;
    logic [ksc_pkg::LETTER_W-1:0]     inv_rdata;
    logic [ksc_pkg::LETTER_W-1:0]     mapped;
    logic [7:0]                       base;
    logic                             s1_move;
    logic                             s1_load;

    assign letter    = ksc_pkg::classify(in_item.data_byte);
    assign accept    = in_valid & ~in_stall;
    assign is_text   = (in_item.func == ksc_pkg::FUNC_TEXT);
    assign s1_move   = ~out_valid_reg | ~out_stall;
    assign s1_load   = ~s1_valid_reg | s1_move;
    assign in_stall  = (state_reg != ST_IDLE) | ~s1_load;

    assign key_we    = accept & (in_item.func == ksc_pkg::FUNC_KEY) & ~sealed_reg
                     & letter.is_letter & ~used_reg[letter.idx]
                     & (fill_reg < ksc_pkg::FILL_W'(ksc_pkg::ALPHABET_SIZE));
    assign seal_we   = (state_reg == ST_SEAL) & ~used_reg[walk_reg];
    assign ram_we    = key_we | seal_we;
    assign wr_letter = (state_reg == ST_SEAL) ? walk_reg : letter.idx;
    assign fill_addr = fill_reg[ksc_pkg::LETTER_W-1:0];

    ksc_ram #(
        .WIDTH (ksc_pkg::LETTER_W),
        .DEPTH (ksc_pkg::ALPHABET_SIZE)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_addr),
        .wdata (wr_letter),
        .re    (accept & is_text),
        .raddr (letter.idx),
        .rdata (fwd_rdata)
    );

    ksc_ram #(
        .WIDTH (ksc_pkg::LETTER_W),
        .DEPTH (ksc_pkg::ALPHABET_SIZE)
    ) u_inv_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_letter),
        .wdata (fill_addr),
        .re    (accept & is_text),
        .raddr (letter.idx),
        .rdata (inv_rdata)
    );

    assign mapped = decrypt_mode_reg ? inv_rdata : fwd_rdata;
    assign base   = s1_reg.is_lower ? ksc_pkg::CHAR_LOWER_A : ksc_pkg::CHAR_UPPER_A;

    always_comb
    begin
        state_next        = state_reg;
        walk_next         = walk_reg;
        used_next         = used_reg;
        fill_next         = fill_reg;
        sealed_next       = sealed_reg;
        decrypt_mode_next = decrypt_mode_reg;

        if (cfg_wr_en)
        begin
            decrypt_mode_next = cfg_wr_data;
        end

        if (ram_we)
        begin
            used_next[wr_letter] = 1'b1;
            fill_next            = fill_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.func == ksc_pkg::FUNC_SEAL && !sealed_reg)
                begin
                    state_next = ST_SEAL;
                    walk_next  = ksc_pkg::LETTER_W'(ksc_pkg::ALPHABET_SIZE - 1);
                end
                if (accept && in_item.func == ksc_pkg::FUNC_CLEAR)
                begin
                    used_next   = '0;
                    fill_next   = '0;
                    sealed_next = 1'b0;
                end
            end
            ST_SEAL:
            begin
                walk_next = walk_reg - 1'b1;
                if (walk_reg == '0)
                begin
                    state_next  = ST_IDLE;
                    sealed_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (s1_load)
        begin
            s1_valid_next     = accept & is_text;
            s1_next.data_byte = in_item.data_byte;
            s1_next.is_letter = letter.is_letter;
            s1_next.is_lower  = letter.is_lower;
            s1_next.sealed    = sealed_reg;
        end

        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
            if (!s1_reg.sealed)
            begin
                out_item_next.out_byte      = s1_reg.data_byte;
                out_item_next.key_not_ready = 1'b1;
            end
            else if (!s1_reg.is_letter)
            begin
                out_item_next.out_byte      = s1_reg.data_byte;
                out_item_next.key_not_ready = 1'b0;
            end
            else
            begin
                out_item_next.out_byte      = 8'(base + {3'b000, mapped});
                out_item_next.key_not_ready = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            walk_reg         <= '0;
            used_reg         <= '0;
            fill_reg         <= '0;
            sealed_reg       <= 1'b0;
            decrypt_mode_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            walk_reg         <= walk_next;
            used_reg         <= used_next;
            fill_reg         <= fill_next;
            sealed_reg       <= sealed_next;
            decrypt_mode_reg <= decrypt_mode_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/ksc_checker.sv @@
// ----------------------------------------------------------------------------
// Keyword substitution cipher port checker
// Watches the top level's ports for handshake and result timing slips.
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_top_macros.svh"

module ksc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_wr_en,
    input logic               cfg_wr_data,
    input logic               in_valid,
    input logic               in_stall,
    input ksc_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input ksc_pkg::out_item_t out_item
);

    logic in_text_acc;
    logic in_other_acc;
    logic cfg_seen;

    assign in_text_acc  = in_valid && !in_stall && in_item.func == ksc_pkg::FUNC_TEXT;
    assign in_other_acc = in_valid && !in_stall && in_item.func != ksc_pkg::FUNC_TEXT;
    assign cfg_seen     = cfg_wr_en | cfg_wr_data;

    `KSC_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid, "result dropped while stalled")
    `KSC_ASSERT_NEXT(a_out_item_held, out_valid && out_stall, $stable(out_item), "stalled result changed")
    `KSC_ASSERT_NOW(a_result_has_text, $rose(out_valid) && !cfg_seen, $past(in_text_acc, 2), "result without text item")
    `KSC_ASSERT_NOW(a_no_result_from_cmd, $past(in_other_acc, 2) && !$past(out_valid), !out_valid, "command item gave a result")

endmodule

bind keyword_substitution_cipher_top ksc_checker u_ksc_checker (.*);

@@ verif/tb_keyword_substitution_cipher_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher testbench
// Drives keyword, seal, clear and text items through the valid/stall
// channels with random idle bursts on both sides. A scoreboard keeps its own
// copy of the key tables, builds the expected text results as items are
// accepted and checks every result field in order. The decrypt mode is
// switched between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher_top;

    class cipher_scoreboard;
        logic [ksc_pkg::LETTER_W-1:0] fwd_map [ksc_pkg::ALPHABET_SIZE];
        logic [ksc_pkg::LETTER_W-1:0] inv_map [ksc_pkg::ALPHABET_SIZE];
        logic [ksc_pkg::ALPHABET_SIZE-1:0] placed;
        int unsigned next_slot;
        bit sealed;
        bit decipher;
        ksc_pkg::out_item_t pending [$];
        int errors;
        int effective;

        function new();
            placed    = '0;
            next_slot = 0;
            sealed    = 1'b0;
            decipher  = 1'b0;
            errors    = 0;
            effective = 0;
            for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++)
            begin
                fwd_map[i] = '0;
                inv_map[i] = '0;
            end
        endfunction

        function void set_mode(bit m);
            decipher = m;
        endfunction

        function void place_letter(logic [ksc_pkg::LETTER_W-1:0] idx);
            if (!placed[idx] && next_slot < ksc_pkg::ALPHABET_SIZE)
            begin
                fwd_map[next_slot] = idx;
                next_slot++;
                placed[idx] = 1'b1;
            end
        endfunction

        function void note_item(ksc_pkg::in_item_t it);
            logic [7:0]                   b;
            bit                           is_letter;
            bit                           is_lower;
            logic [ksc_pkg::LETTER_W-1:0] idx;
            logic [ksc_pkg::LETTER_W-1:0] mapped;
            ksc_pkg::out_item_t           res;
            b         = it.data_byte;
            is_letter = 1'b0;
            is_lower  = 1'b0;
            idx       = '0;
            if (b >= ksc_pkg::CHAR_UPPER_A && b <= ksc_pkg::CHAR_UPPER_Z)
            begin
                is_letter = 1'b1;
                idx       = ksc_pkg::LETTER_W'(b - ksc_pkg::CHAR_UPPER_A);
            end
            else if (b >= ksc_pkg::CHAR_LOWER_A && b <= ksc_pkg::CHAR_LOWER_Z)
            begin
                is_letter = 1'b1;
                is_lower  = 1'b1;
                idx       = ksc_pkg::LETTER_W'(b - ksc_pkg::CHAR_LOWER_A);
            end
            case (it.func)
                ksc_pkg::FUNC_KEY:
                begin
                    if (!sealed && is_letter)
                    begin
                        place_letter(idx);
                        effective++;
                    end
                end
                ksc_pkg::FUNC_SEAL:
                begin
                    if (!sealed)
                    begin
                        for (int i = ksc_pkg::ALPHABET_SIZE - 1; i >= 0; i--)
                            place_letter(ksc_pkg::LETTER_W'(i));
                        for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++)
                            inv_map[fwd_map[i]] = ksc_pkg::LETTER_W'(i);
                        sealed = 1'b1;
                        effective++;
                    end
                end
                ksc_pkg::FUNC_CLEAR:
                begin
                    placed    = '0;
                    next_slot = 0;
                    sealed    = 1'b0;
                    effective++;
                end
                default:
                begin
                    res.out_byte      = b;
                    res.key_not_ready = !sealed;
                    if (sealed && is_letter)
                    begin
                        mapped       = decipher ? inv_map[idx] : fwd_map[idx];
                        res.out_byte = (is_lower ? ksc_pkg::CHAR_LOWER_A
                                                 : ksc_pkg::CHAR_UPPER_A) + 8'(mapped);
                    end
                    pending.push_back(res);
                    effective++;
                end
            endcase
        endfunction

        function void check_result(ksc_pkg::out_item_t got);
            ksc_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%b",
                         $time, got.out_byte, got.key_not_ready);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte expected %h actual %h",
                         $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.key_not_ready !== want.key_not_ready)
            begin
                $display("%0t: key_not_ready expected %b actual %b",
                         $time, want.key_not_ready, got.key_not_ready);
                errors++;
            end
        endfunction

        function void wrap_up();
            if (pending.size() != 0)
            begin
                $display("%0t: results missing, expected %0d more, actual 0",
                         $time, pending.size());
                errors++;
            end
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    ksc_pkg::in_item_t  in_item     = '{func: ksc_pkg::FUNC_KEY, data_byte: 8'h00};
    logic               out_valid;
    logic               out_stall   = 1'b0;
    ksc_pkg::out_item_t out_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold     = 0;

    cipher_scoreboard sb = new();

    keyword_substitution_cipher_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
        end
    end

    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold = recv_hold - 1;
            out_stall <= 1'b1;
        end
        else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
        begin
            recv_hold = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] pick_letter();
        logic [7:0] idx;
        idx = 8'($urandom_range(0, ksc_pkg::ALPHABET_SIZE - 1));
        return ($urandom_range(0, 1) != 0) ? ksc_pkg::CHAR_LOWER_A + idx
                                           : ksc_pkg::CHAR_UPPER_A + idx;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(128, 255));
            2:       return ($urandom_range(0, 1) != 0) ? 8'h40 : 8'h5B;
            3:       return ($urandom_range(0, 1) != 0) ? 8'h60 : 8'h7B;
            default: return pick_letter();
        endcase
    endfunction

    task automatic send_item(input ksc_pkg::func_t f, input logic [7:0] b);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.func      <= f;
        in_item.data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic run_directed();
        send_item(ksc_pkg::FUNC_TEXT, "A");
        send_item(ksc_pkg::FUNC_TEXT, 8'hFF);
        send_item(ksc_pkg::FUNC_KEY, "Z");
        send_item(ksc_pkg::FUNC_KEY, "e");
        send_item(ksc_pkg::FUNC_KEY, "B");
        send_item(ksc_pkg::FUNC_KEY, "r");
        send_item(ksc_pkg::FUNC_KEY, "a");
        send_item(ksc_pkg::FUNC_KEY, "z");
        send_item(ksc_pkg::FUNC_KEY, 8'hC1);
        send_item(ksc_pkg::FUNC_KEY, 8'h40);
        send_item(ksc_pkg::FUNC_KEY, 8'h7B);
        send_item(ksc_pkg::FUNC_SEAL, 8'h00);
        send_item(ksc_pkg::FUNC_SEAL, 8'hFF);
        send_item(ksc_pkg::FUNC_KEY, "Q");
        send_item(ksc_pkg::FUNC_TEXT, "A");
        send_item(ksc_pkg::FUNC_TEXT, "z");
        send_item(ksc_pkg::FUNC_TEXT, "m");
        send_item(ksc_pkg::FUNC_TEXT, 8'h5B);
        send_item(ksc_pkg::FUNC_TEXT, 8'h60);
        send_item(ksc_pkg::FUNC_TEXT, 8'h00);
        send_item(ksc_pkg::FUNC_TEXT, 8'hE1);
        send_item(ksc_pkg::FUNC_CLEAR, 8'h5A);
        send_item(ksc_pkg::FUNC_TEXT, "b");
        send_item(ksc_pkg::FUNC_KEY, "Q");
        send_item(ksc_pkg::FUNC_SEAL, 8'h00);
    endtask

    task automatic run_sequence(input bit quiet);
        int len;
        int step;
        int start;
        if (!quiet)
        begin
            send_idle_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
            recv_idle_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
        end
        if ($urandom_range(0, 99) < 8)
        begin
            len = $urandom_range(1, 8);
            repeat (len) send_item(ksc_pkg::func_t'($urandom_range(0, 3)),
                                   8'($urandom_range(0, 255)));
            return;
        end
        send_item(ksc_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 3);
            repeat (len) send_item(ksc_pkg::FUNC_TEXT, pick_text_byte());
        end
        if ($urandom_range(0, 19) == 0)
        begin
            step  = $urandom_range(0, 12) * 2 + 1;
            step  = (step == 13) ? 1 : step;
            start = $urandom_range(0, ksc_pkg::ALPHABET_SIZE - 1);
            for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++)
                send_item(ksc_pkg::FUNC_KEY, ksc_pkg::CHAR_UPPER_A
                          + 8'((start + i * step) % ksc_pkg::ALPHABET_SIZE));
            send_item(ksc_pkg::FUNC_KEY, pick_letter());
        end
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
            repeat (len)
                send_item(ksc_pkg::FUNC_KEY, ($urandom_range(0, 99) < 85)
                                             ? pick_letter() : 8'($urandom_range(0, 255)));
        end
        send_item(ksc_pkg::FUNC_SEAL, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            send_item(ksc_pkg::FUNC_SEAL, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            send_item(ksc_pkg::FUNC_KEY, pick_letter());
        len = $urandom_range(1, 30);
        repeat (len) send_item(ksc_pkg::FUNC_TEXT, pick_text_byte());
    endtask

    initial
    begin
        int waited;
        bit m;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);
        run_directed();
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_pipeline();
            m = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            write_mode(m);
            if (phase == 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (3) send_item(ksc_pkg::FUNC_TEXT, pick_text_byte());
            while (sb.effective < 25 + (phase + 1) * 125)
                run_sequence(phase == 5);
        end
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        sb.wrap_up();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
